// ===== rtl/topic_posterior_infer_assert.svh =====
// Assertion macros for the topic posterior inference block
`ifndef TOPIC_POSTERIOR_INFER_ASSERT_SVH
`define TOPIC_POSTERIOR_INFER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TPI_ASSERT_NOW(label, ant, con) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error("topic_posterior_infer check failed");

// Next-cycle implication, disabled during reset
`define TPI_ASSERT_NEXT(label, ant, con) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error("topic_posterior_infer check failed");

// Next-cycle implication that also holds across reset
`define TPI_ASSERT_ALWAYS(label, ant, con) \
    label: assert property (@(posedge aclk) (ant) |=> (con)) \
        else $error("topic_posterior_infer check failed");

`endif

// ===== rtl/tpi_pkg.sv =====
// Shared types and constants for the topic posterior inference block
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

    localparam int ACC_BITS = 32;
    localparam int QBITS    = 17;
    localparam int QDEPTH   = 4;

    localparam logic [1:0] KIND_PRIOR = 2'd0;
    localparam logic [1:0] KIND_TABLE = 2'd1;
    localparam logic [1:0] KIND_WORD  = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_VOCAB = 1'b1;

    localparam logic [12:0] VOCAB_RESET = 13'd4096;

    typedef enum logic [1:0] {
        CMD_PRIOR,
        CMD_TABLE,
        CMD_WORD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  topic;
        logic [15:0] word;
        logic [15:0] value;
        logic        in_range;
        logic        last;
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WORD,
        S_INIT_RD,
        S_INIT_WR,
        S_P1_RD,
        S_P1_MUL,
        S_P1_ACC,
        S_P2_RD,
        S_P2_GO,
        S_P2_WAIT,
        S_P2_WR,
        S_WORD_END,
        S_T_RD,
        S_T_ACC,
        S_O_RD,
        S_O_GO,
        S_O_WAIT,
        S_O_SEND
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/tpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tpi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tpi_front.sv =====
// Front end: accept input transactions, classify them and queue commands
`timescale 1ns / 1ps
`default_nettype none

module tpi_front #(
    parameter int TOPICS = 16,
    parameter int VOCAB  = 4096
) (
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_kind,
    input  wire logic [3:0]   s_topic,
    input  wire logic [15:0]  s_word,
    input  wire logic [15:0]  s_value,
    input  wire logic         s_last,
    input  wire logic [12:0]  vocab_in_use,
    input  wire logic         q_full,
    output logic              q_push,
    output tpi_pkg::cmd_t     q_cmd
);

    import tpi_pkg::*;

    logic topic_ok;
    logic keep;

    assign topic_ok = 32'(s_topic) < TOPICS;

    always_comb begin
        q_cmd.topic    = s_topic;
        q_cmd.word     = s_word;
        q_cmd.value    = s_value;
        q_cmd.last     = s_last;
        q_cmd.in_range = (32'(s_word) < 32'(vocab_in_use)) && (32'(s_word) < VOCAB);
        q_cmd.kind     = CMD_WORD;
        keep           = 1'b0;
        unique case (s_kind)
            KIND_PRIOR: begin
                q_cmd.kind = CMD_PRIOR;
                keep       = topic_ok;
            end
            KIND_TABLE: begin
                q_cmd.kind = CMD_TABLE;
                keep       = topic_ok && (32'(s_word) < VOCAB);
            end
            KIND_WORD: begin
                q_cmd.kind = CMD_WORD;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

`default_nettype wire

// ===== rtl/tpi_queue.sv =====
// Command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module tpi_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  tpi_pkg::cmd_t      push_cmd,
    input  wire logic          pop,
    output tpi_pkg::cmd_t      head,
    output logic               full,
    output logic               empty
);

    import tpi_pkg::*;

    localparam int PTRW = $clog2(QDEPTH);

    cmd_t            slot_reg [QDEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTRW:0]   count_reg, count_next;

    assign full  = count_reg == (PTRW+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpi_div.sv =====
// Restoring divider giving the Q1.16 ratio of a part to a total
`timescale 1ns / 1ps
`default_nettype none

module tpi_div #(
    parameter int W = 72
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [W-1:0]              numer,
    input  wire logic [W-1:0]              denom,
    output logic                           done,
    output logic [tpi_pkg::QBITS-1:0]      quot
);

    import tpi_pkg::*;

    localparam int CW = $clog2(QBITS + 1);

    logic [W:0]       rem_reg;
    logic [W-1:0]     den_reg;
    logic [QBITS-1:0] quot_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;
    logic [W:0]       diff;

    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QBITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, numer};
            den_reg  <= denom;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= {diff[W-1:0], 1'b0};
            quot_reg <= {quot_reg[QBITS-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpi_back.sv =====
// Back end: table and accumulator updates, normalisation and result output
`timescale 1ns / 1ps
`default_nettype none

module tpi_back #(
    parameter int TOPICS    = 16,
    parameter int VOCAB     = 4096,
    parameter int PROB_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          mode,
    input  wire logic          q_empty,
    input  tpi_pkg::cmd_t      q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [3:0]         out_topic,
    output logic [15:0]        out_prob,
    output logic               out_empty,
    output logic               out_final
);

    import tpi_pkg::*;

    localparam int TW  = $clog2(TOPICS);
    localparam int TAW = $clog2(TOPICS * VOCAB);
    localparam int MW  = ACC_BITS + PROB_BITS;
    localparam int SW  = MW + TW;
    localparam logic [TW-1:0] LAST_K = TW'(TOPICS - 1);

    back_state_t   state_reg, state_next;
    logic [TW-1:0] k_reg, k_next;
    logic          doc_open_reg, doc_open_next;
    logic          doc_mode_reg, doc_mode_next;
    logic          seen_reg, seen_next;
    cmd_t          cmd_reg, cmd_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [MW-1:0] prod_reg, prod_next;
    logic [15:0]   prob_reg, prob_next;

    logic                 prior_we;
    logic [PROB_BITS-1:0] prior_rd;
    logic                 table_we;
    logic [TAW-1:0]       table_waddr;
    logic [TAW-1:0]       table_raddr;
    logic [PROB_BITS-1:0] table_rd;
    logic                 acc_we;
    logic [ACC_BITS-1:0]  acc_wdata;
    logic [ACC_BITS-1:0]  acc_rd;
    logic                 prod_we;
    logic [MW-1:0]        prod_rd;

    logic                 div_start;
    logic [SW-1:0]        div_numer;
    logic                 div_done;
    logic [QBITS-1:0]     div_quot;

    logic [ACC_BITS-1:0]  base;
    logic [ACC_BITS:0]    acc_sum;
    logic [SW-1:0]        sum_prod;
    logic [SW-1:0]        sum_acc;
    logic                 last_k;

    assign table_waddr = TAW'(32'(q_head.topic) * VOCAB + 32'(q_head.word));
    assign table_raddr = TAW'(32'(k_reg) * VOCAB + 32'(cmd_reg.word));
    assign base        = doc_mode_reg ? acc_rd : ACC_BITS'(prior_rd);
    assign acc_sum     = {1'b0, acc_rd} + (ACC_BITS+1)'(div_quot);
    assign sum_prod    = sum_reg + SW'(prod_reg);
    assign sum_acc     = sum_reg + SW'(acc_rd);
    assign last_k      = k_reg == LAST_K;
    assign div_numer   = (state_reg == S_O_GO) ? SW'(acc_rd) : SW'(prod_rd);

    tpi_ram #(.WIDTH(PROB_BITS), .DEPTH(TOPICS)) u_prior (
        .aclk  (aclk),
        .we    (prior_we),
        .waddr (TW'(q_head.topic)),
        .wdata (PROB_BITS'(q_head.value)),
        .raddr (k_reg),
        .rdata (prior_rd)
    );

    tpi_ram #(.WIDTH(PROB_BITS), .DEPTH(TOPICS * VOCAB)) u_table (
        .aclk  (aclk),
        .we    (table_we),
        .waddr (table_waddr),
        .wdata (PROB_BITS'(q_head.value)),
        .raddr (table_raddr),
        .rdata (table_rd)
    );

    tpi_ram #(.WIDTH(ACC_BITS), .DEPTH(TOPICS)) u_acc (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (k_reg),
        .wdata (acc_wdata),
        .raddr (k_reg),
        .rdata (acc_rd)
    );

    tpi_ram #(.WIDTH(MW), .DEPTH(TOPICS)) u_prod (
        .aclk  (aclk),
        .we    (prod_we),
        .waddr (k_reg),
        .wdata (prod_reg),
        .raddr (k_reg),
        .rdata (prod_rd)
    );

    tpi_div #(.W(SW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        doc_open_next = doc_open_reg;
        doc_mode_next = doc_mode_reg;
        seen_next     = seen_reg;
        cmd_next      = cmd_reg;
        sum_next      = sum_reg;
        prod_next     = prod_reg;
        prob_next     = prob_reg;
        q_pop         = 1'b0;
        prior_we      = 1'b0;
        table_we      = 1'b0;
        acc_we        = 1'b0;
        acc_wdata     = '0;
        prod_we       = 1'b0;
        div_start     = 1'b0;
        m_tvalid      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    unique case (q_head.kind)
                        CMD_PRIOR: prior_we   = 1'b1;
                        CMD_TABLE: table_we   = 1'b1;
                        CMD_WORD:  state_next = S_WORD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_WORD: begin
                k_next = '0;
                if (!doc_open_reg) begin
                    doc_open_next = 1'b1;
                    doc_mode_next = mode;
                    seen_next     = 1'b0;
                    state_next    = S_INIT_RD;
                end else if (cmd_reg.in_range) begin
                    seen_next  = seen_reg | !doc_mode_reg;
                    sum_next   = '0;
                    state_next = S_P1_RD;
                end else begin
                    state_next = S_WORD_END;
                end
            end
            S_INIT_RD: state_next = S_INIT_WR;
            S_INIT_WR: begin
                acc_we    = 1'b1;
                acc_wdata = doc_mode_reg ? ACC_BITS'(prior_rd) : '0;
                if (last_k) begin
                    state_next = S_WORD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_INIT_RD;
                end
            end
            S_P1_RD: state_next = S_P1_MUL;
            S_P1_MUL: begin
                prod_next  = MW'(base) * MW'(table_rd);
                state_next = S_P1_ACC;
            end
            S_P1_ACC: begin
                prod_we  = 1'b1;
                sum_next = sum_prod;
                if (last_k) begin
                    k_next     = '0;
                    state_next = (sum_prod == '0) ? S_WORD_END : S_P2_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_P1_RD;
                end
            end
            S_P2_RD: state_next = S_P2_GO;
            S_P2_GO: begin
                div_start  = 1'b1;
                state_next = S_P2_WAIT;
            end
            S_P2_WAIT: begin
                if (div_done) begin
                    state_next = S_P2_WR;
                end
            end
            S_P2_WR: begin
                acc_we = 1'b1;
                if (doc_mode_reg) begin
                    acc_wdata = ACC_BITS'(div_quot);
                end else begin
                    acc_wdata = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
                end
                if (last_k) begin
                    state_next = S_WORD_END;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_P2_RD;
                end
            end
            S_WORD_END: begin
                k_next   = '0;
                sum_next = '0;
                state_next = cmd_reg.last ? S_T_RD : S_IDLE;
            end
            S_T_RD: state_next = S_T_ACC;
            S_T_ACC: begin
                sum_next = sum_acc;
                if (last_k) begin
                    k_next     = '0;
                    state_next = S_O_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_T_RD;
                end
            end
            S_O_RD: state_next = S_O_GO;
            S_O_GO: begin
                div_start  = 1'b1;
                state_next = S_O_WAIT;
            end
            S_O_WAIT: begin
                if (div_done) begin
                    if (sum_reg == '0) begin
                        prob_next = '0;
                    end else if (div_quot[QBITS-1]) begin
                        prob_next = '1;
                    end else begin
                        prob_next = div_quot[15:0];
                    end
                    state_next = S_O_SEND;
                end
            end
            S_O_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (last_k) begin
                        doc_open_next = 1'b0;
                        state_next    = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_O_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            doc_open_reg <= 1'b0;
            doc_mode_reg <= 1'b0;
            seen_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            doc_open_reg <= doc_open_next;
            doc_mode_reg <= doc_mode_next;
            seen_reg     <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        prob_reg <= prob_next;
    end

    assign out_topic = 4'(k_reg);
    assign out_prob  = prob_reg;
    assign out_empty = !doc_mode_reg && !seen_reg;
    assign out_final = last_k;

endmodule

`default_nettype wire

// ===== rtl/topic_posterior_infer.sv =====
// Top level of the topic posterior inference block
// Usage:
//   The s_ channel carries loads and document words. tuser is the kind: prior load,
//   word-topic table load or document word; tlast marks the last word of a document.
//   After the last word, TOPICS transactions leave on the m_ channel in topic order,
//   tlast set on the final one, tuser set when sum mode saw no in-vocabulary word.
//   The APB port holds mode (0x0) and vocab_in_use (0x4); write only while idle.
// Sequence (T = TOPICS):
//   Load: one pass through the command queue and one RAM write.
//   First word of a document: a read and a write per topic to preset the accumulators.
//   In-vocabulary word: a read, multiply and accumulate step per topic, then T divisions
//   on the shared 17-step divider when the word's product sum is non-zero.
//   Last word: a further read and add per topic to total, then one division per result.
//   The four-entry queue takes new transactions while the back end works.
// Reset clears the queue, the document state and the configuration registers; the tables
// hold no defined contents until loaded. A stalled m_ transaction holds its payload and
// the back end waits; input is taken until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module topic_posterior_infer #(
    parameter int TOPICS    = 16,
    parameter int VOCAB     = 4096,
    parameter int PROB_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // topic[3:0], word[19:4], value[35:20], zero pad
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // topic_out[3:0], prob[19:4], zero pad
    output logic             m_tuser,   // empty_res
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import tpi_pkg::*;

    logic        mode_reg;
    logic [12:0] vocab_reg;
    logic        cfg_wr;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    cmd_t        q_cmd;
    cmd_t        q_head;
    logic [3:0]  out_topic;
    logic [15:0] out_prob;
    logic        out_empty;
    logic        out_final;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_VOCAB) ? {19'b0, vocab_reg} : {31'b0, mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            vocab_reg <= VOCAB_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
                mode_reg <= pwdata[0];
            end else begin
                vocab_reg <= pwdata[12:0];
            end
        end
    end

    tpi_front #(.TOPICS(TOPICS), .VOCAB(VOCAB)) u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_kind       (s_tuser),
        .s_topic      (s_tdata[3:0]),
        .s_word       (s_tdata[19:4]),
        .s_value      (s_tdata[35:20]),
        .s_last       (s_tlast),
        .vocab_in_use (vocab_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    tpi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tpi_back #(.TOPICS(TOPICS), .VOCAB(VOCAB), .PROB_BITS(PROB_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_topic (out_topic),
        .out_prob  (out_prob),
        .out_empty (out_empty),
        .out_final (out_final)
    );

    assign m_tdata = {4'b0, out_prob, out_topic};
    assign m_tuser = out_empty;
    assign m_tlast = out_final;

endmodule

`default_nettype wire

// ===== rtl/tpi_checker.sv =====
// Port-level checks for the topic posterior inference block
`timescale 1ns / 1ps
`default_nettype none

`include "topic_posterior_infer_assert.svh"

module tpi_port_checks #(
    parameter int TOPICS = 16
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `TPI_ASSERT_NOW(a_last_topic, m_tvalid && m_tlast, m_tdata[3:0] == 4'(TOPICS - 1))
    `TPI_ASSERT_NOW(a_empty_zero, m_tvalid && m_tuser, m_tdata[19:4] == 16'd0)
    `TPI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TPI_ASSERT_ALWAYS(a_reset_quiet, !aresetn, !m_tvalid)

endmodule

bind topic_posterior_infer tpi_port_checks #(.TOPICS(TOPICS)) u_tpi_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== dv/tpi_checker.sv =====
// Checker for the topic posterior inference block: predicts topic distributions and compares
`timescale 1ns / 1ps
`default_nettype none

module tpi_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // topic[3:0], word[19:4], value[35:20], zero pad
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // topic_out[3:0], prob[19:4], zero pad
    input  wire logic        m_tuser,   // empty_res
    input  wire logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending
);

    import tpi_pkg::*;

    localparam int NT = 16;
    localparam int NV = 4096;

    typedef struct packed {
        logic [3:0]  topic;
        logic [15:0] prob;
        logic        empty;
        logic        fin;
    } topic_result_t;

    topic_result_t posterior_q[$];

    logic [15:0] prior_m   [NT];
    logic [15:0] word_prob [NT*NV];
    logic [31:0] acc       [NT];
    bit          seen;
    bit          doc_open;
    bit          doc_mode;
    bit          mode_r;
    logic [12:0] vocab_r;

    function automatic void absorb_word(int w);
        logic [63:0] prod [NT];
        logic [63:0] sum;
        logic [63:0] base;
        logic [63:0] q;
        logic [63:0] a;
        int k;
        sum = 0;
        for (k = 0; k < NT; k++) begin
            base = doc_mode ? 64'(acc[k]) : 64'(prior_m[k]);
            prod[k] = base * 64'(word_prob[k*NV + w]);
            sum += prod[k];
        end
        if (!doc_mode)
            seen = 1;
        if (sum == 0)
            return;
        for (k = 0; k < NT; k++) begin
            q = (prod[k] << 16) / sum;
            if (doc_mode) begin
                acc[k] = q[31:0];
            end else begin
                a = 64'(acc[k]) + q;
                acc[k] = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
            end
        end
    endfunction

    function automatic void emit_distribution();
        logic [63:0] total;
        logic [63:0] p;
        topic_result_t r;
        int k;
        total = 0;
        for (k = 0; k < NT; k++)
            total += 64'(acc[k]);
        for (k = 0; k < NT; k++) begin
            p = (total == 0) ? 64'd0 : (64'(acc[k]) << 16) / total;
            if (p > 64'hFFFF)
                p = 64'hFFFF;
            r.topic = 4'(k);
            r.prob  = p[15:0];
            r.empty = !doc_mode && !seen;
            r.fin   = (k == NT - 1);
            posterior_q.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin
        logic [3:0]  topic;
        logic [15:0] word;
        logic [15:0] value;
        int          limit;
        int          k;
        topic_result_t want;
        if (!aresetn) begin
            posterior_q.delete();
            for (k = 0; k < NT; k++) begin
                acc[k] = 0;
                prior_m[k] = 0;
            end
            seen = 0;
            doc_open = 0;
            doc_mode = 0;
            mode_r = 0;
            vocab_r = VOCAB_RESET;
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MODE)
                    mode_r = pwdata[0];
                else
                    vocab_r = pwdata[12:0];
            end
            if (s_tvalid && s_tready) begin
                topic = s_tdata[3:0];
                word  = s_tdata[19:4];
                value = s_tdata[35:20];
                case (s_tuser)
                    KIND_PRIOR: prior_m[topic] = value;
                    KIND_TABLE: begin
                        if (word < NV)
                            word_prob[int'(topic)*NV + word] = value;
                    end
                    KIND_WORD: begin
                        if (!doc_open) begin
                            doc_open = 1;
                            doc_mode = mode_r;
                            seen = 0;
                            for (k = 0; k < NT; k++)
                                acc[k] = mode_r ? 32'(prior_m[k]) : 32'd0;
                        end
                        limit = (vocab_r < NV) ? int'(vocab_r) : NV;
                        if (word < limit)
                            absorb_word(word);
                        if (s_tlast) begin
                            doc_open = 0;
                            emit_distribution();
                        end
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (posterior_q.size() == 0) begin
                    $error("unexpected result: topic_out %0d prob %0d", m_tdata[3:0],
                           m_tdata[19:4]);
                    fail_count++;
                end else begin
                    want = posterior_q.pop_front();
                    if (m_tdata[3:0] !== want.topic) begin
                        $error("topic_out: expected %0d, got %0d", want.topic, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[19:4] !== want.prob) begin
                        $error("prob: expected %0d, got %0d", want.prob, m_tdata[19:4]);
                        fail_count++;
                    end
                    if (m_tuser !== want.empty) begin
                        $error("empty_res: expected %0d, got %0d", want.empty, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== want.fin) begin
                        $error("final_res: expected %0d, got %0d", want.fin, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = posterior_q.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top for the topic posterior inference block: stimulus, idling and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import tpi_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int         NV         = 4096;
    localparam int         SETTLE     = 2000;
    localparam int         LIMIT      = 2_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // topic[3:0], word[19:4], value[35:20], zero pad
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // topic_out[3:0], prob[19:4], zero pad
    logic        m_tuser;   // empty_res
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          vocab_now;
    logic [15:0] col_mask [NV];
    int          usable_q[$];

    topic_posterior_infer DUT (.*);

    tpi_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [15:0] rand_prob();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(65535));
    endfunction

    task automatic send(logic [1:0] kind, logic [3:0] topic, logic [15:0] word,
                        logic [15:0] value, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, value, word, topic};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic load_table(logic [3:0] topic, logic [15:0] word, logic [15:0] value);
        send(KIND_TABLE, topic, word, value, 0);
        if (word < NV && col_mask[word] != 16'hFFFF) begin
            col_mask[word][topic] = 1;
            if (col_mask[word] == 16'hFFFF)
                usable_q.push_back(word);
        end
    endtask

    task automatic load_column(logic [15:0] word, bit zero);
        int t;
        for (t = 0; t < 16; t++)
            load_table(4'(t), word, zero ? 16'd0 : rand_prob());
    endtask

    task automatic load_priors(bit zero);
        int t;
        for (t = 0; t < 16; t++)
            send(KIND_PRIOR, 4'(t), 16'($urandom()), zero ? 16'd0 :
                 (t == 0) ? 16'hFFFF : (t == 3) ? 16'd0 : rand_prob(), t == 5);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel    <= 0;
        penable <= 0;
        if (reg_sel == REG_VOCAB)
            vocab_now = int'(value[12:0]);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] doc_word();
        logic [15:0] w;
        int limit;
        limit = (vocab_now < NV) ? vocab_now : NV;
        w = usable_q[$urandom_range(usable_q.size() - 1)];
        if ($urandom_range(99) < 20) begin
            w = 16'($urandom());
            if (w < limit && col_mask[w] != 16'hFFFF)
                w = usable_q[$urandom_range(usable_q.size() - 1)];
        end
        return w;
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            send(KIND_WORD, 4'($urandom()), doc_word(), 16'($urandom()),
                 $urandom_range(3) == 0);
        else if (r < 87)
            load_table(4'($urandom()), ($urandom_range(1) == 1) ?
                       usable_q[$urandom_range(usable_q.size() - 1)] : 16'($urandom()),
                       rand_prob());
        else if (r < 95)
            send(KIND_PRIOR, 4'($urandom()), 16'($urandom()), rand_prob(), $urandom_range(1));
        else
            send(KIND_SPARE, 4'($urandom()), 16'($urandom()), 16'($urandom()),
                 $urandom_range(1));
    endtask

    initial begin
        int ph;
        int i;
        int w;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        hold_req = 0;
        vocab_now = NV;
        tx_idle_pct = 15;
        rx_idle_pct = 62;
        for (i = 0; i < NV; i++)
            col_mask[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        apb_write(REG_MODE, 32'd0);
        apb_write(REG_VOCAB, 32'd4096);
        load_priors(0);
        load_column(16'd0, 0);
        load_column(16'd1, 0);
        load_column(16'd2, 0);
        load_column(16'd4095, 0);
        load_column(16'd5, 1);
        for (i = 0; i < 1; i++) begin
            w = $urandom_range(6, 4094);
            load_column(16'(w), 0);
        end
        load_table(4'hF, 16'hFFFF, 16'hFFFF);
        send(KIND_SPARE, 4'hA, 16'h1234, 16'hFFFF, 0);
        send(KIND_SPARE, 4'h5, 16'hABCD, 16'h0000, 1);
        // sum mode: mixed in and out of vocabulary
        send(KIND_WORD, 4'h0, 16'd1, 16'd0, 0);
        send(KIND_WORD, 4'h0, 16'd2, 16'd0, 0);
        send(KIND_WORD, 4'hF, 16'hFFFF, 16'hFFFF, 0);
        send(KIND_WORD, 4'h0, 16'd4095, 16'd0, 1);
        // no in-vocabulary word, then a zero column
        send(KIND_WORD, 4'h0, 16'h1000, 16'd0, 1);
        send(KIND_WORD, 4'h0, 16'd5, 16'd0, 1);
        settle();

        apb_write(REG_MODE, 32'd1);
        send(KIND_WORD, 4'h0, 16'd1, 16'd0, 0);
        send(KIND_WORD, 4'h0, 16'd5, 16'd0, 0);
        send(KIND_WORD, 4'h0, 16'd2, 16'd0, 1);
        // zero prior: every prob comes out zero
        load_priors(1);
        send(KIND_WORD, 4'h0, 16'd0, 16'd0, 1);
        load_priors(0);
        settle();

        apb_write(REG_MODE, 32'd0);
        apb_write(REG_VOCAB, 32'd1);
        send(KIND_WORD, 4'h0, 16'd0, 16'd0, 0);
        send(KIND_WORD, 4'h0, 16'd1, 16'd0, 0);
        send(KIND_WORD, 4'h0, 16'd4095, 16'd0, 1);
        settle();

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 62 : 0;
            rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 15 : 0;
            apb_write(REG_MODE, (ph == 1) ? 32'd1 : (ph == 0) ? 32'd0 : $urandom_range(1));
            apb_write(REG_VOCAB, (ph == 1) ? $urandom_range(1, 4096) : 32'd4096);
            if (ph == 2)
                hold_req = 1;
            for (i = 0; i < 13; i++)
                random_item();
            send(KIND_WORD, 4'h0, usable_q[$urandom_range(usable_q.size() - 1)], 16'd0, 1);
            settle();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/tpi_pkg.sv
rtl/tpi_ram.sv
rtl/tpi_front.sv
rtl/tpi_queue.sv
rtl/tpi_div.sv
rtl/tpi_back.sv
rtl/topic_posterior_infer.sv
rtl/tpi_checker.sv
dv/tpi_checker.sv
dv/tb_top.sv
